// ----- src/hfl_pkg.sv -----
package hfl_pkg;

    // parse phases
    localparam logic [2:0] PH_NAME  = 3'd0;
    localparam logic [2:0] PH_SKIP  = 3'd1;
    localparam logic [2:0] PH_VALUE = 3'd2;
    localparam logic [2:0] PH_REST  = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    // result kinds
    localparam logic [1:0] K_VALUE    = 2'd0;
    localparam logic [1:0] K_FOUND    = 2'd1;
    localparam logic [1:0] K_NOTFOUND = 2'd2;
    localparam logic [1:0] K_ERROR    = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_LIMIT = 2'd3;

    localparam logic [6:0] VAL_LIMIT_RST = 7'd64;

    // characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // datapath operations
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_END       = 4'd1;
    localparam logic [3:0] OP_LINE_END  = 4'd2;
    localparam logic [3:0] OP_ORD_CR    = 4'd3;
    localparam logic [3:0] OP_ORD_BYTE  = 4'd4;
    localparam logic [3:0] OP_SET_CR    = 4'd5;
    localparam logic [3:0] OP_RD        = 4'd6;
    localparam logic [3:0] OP_EMIT_BYTE = 4'd7;
    localparam logic [3:0] OP_FOUND     = 4'd8;

    typedef struct packed {
        logic       load;
        logic [3:0] op;
    } hfl_cmd_t;

    typedef struct packed {
        logic act;
        logic done;
        logic pend;
        logic is_lf;
        logic is_cr;
        logic in_value;
        logic over;
        logic count_zero;
        logic rd_last;
        logic out_free;
    } hfl_status_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

// ----- src/hfl_ctrl.sv -----
module hfl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hfl_pkg::hfl_status_t status,
    output hfl_pkg::hfl_cmd_t    cmd
);
    import hfl_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_RD_REQ  = 3'd2;
    localparam logic [2:0] S_RD_EMIT = 3'd3;
    localparam logic [2:0] S_FOUND   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                // every step may produce a word, so wait for a free output slot
                if (status.out_free) begin
                    if (status.act) begin
                        cmd.op     = OP_END;
                        state_next = S_IDLE;
                    end else if (status.done) begin
                        state_next = S_IDLE;
                    end else if (status.pend && status.is_lf) begin
                        cmd.op = OP_LINE_END;
                        if (status.in_value && !status.over) begin
                            state_next = status.count_zero ? S_FOUND : S_RD_REQ;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end else if (status.pend) begin
                        // stale cr is an ordinary byte, then revisit this byte
                        cmd.op     = OP_ORD_CR;
                        state_next = S_CHECK;
                    end else if (status.is_cr) begin
                        cmd.op     = OP_SET_CR;
                        state_next = S_IDLE;
                    end else begin
                        cmd.op     = OP_ORD_BYTE;
                        state_next = S_IDLE;
                    end
                end
            end
            S_RD_REQ: begin
                cmd.op     = OP_RD;
                state_next = S_RD_EMIT;
            end
            S_RD_EMIT: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT_BYTE;
                    state_next = status.rd_last ? S_FOUND : S_RD_REQ;
                end
            end
            S_FOUND: begin
                if (status.out_free) begin
                    cmd.op     = OP_FOUND;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/hfl_datapath.sv -----
module hfl_datapath #(
    parameter int NAME_MAX  = 16,
    parameter int VALUE_MAX = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [hfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic                           s_action,
    input  logic [7:0]                     s_text_byte,
    input  hfl_pkg::hfl_cmd_t              cmd,
    output hfl_pkg::hfl_status_t           status,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_kind,
    output logic [7:0]                     m_value_byte,
    output logic                           m_last
);
    import hfl_pkg::*;

    localparam int         IDX_W    = $clog2(VALUE_MAX);
    localparam logic [4:0] NAME_MAX_W  = 5'(NAME_MAX);
    localparam logic [6:0] VALUE_MAX_W = 7'(VALUE_MAX);

    // configuration
    logic [63:0] name_low_reg;
    logic [63:0] name_high_reg;
    logic [4:0]  name_len_reg;
    logic [6:0]  val_limit_reg;

    // latched input word
    logic       act_reg;
    logic [7:0] byte_reg;

    // parse state
    logic [2:0] phase_reg,    phase_next;
    logic [4:0] pos_reg,      pos_next;
    logic       mism_reg,     mism_next;
    logic       pend_reg,     pend_next;
    logic       prev_emp_reg, prev_emp_next;
    logic [6:0] count_reg,    count_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;

    // value store
    logic [7:0] mem [VALUE_MAX];
    logic [7:0] rd_data_reg;
    logic       wr_en;
    logic [7:0] wr_data;

    // output register
    logic       out_valid_reg;
    logic [1:0] out_kind_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    logic         emit;
    logic [1:0]   emit_kind;
    logic [7:0]   emit_byte;
    logic [6:0]   eff_limit;
    logic [6:0]   count_inc;
    logic [4:0]   pos_inc;
    logic [7:0]   c;
    logic [127:0] name_vec;
    logic [7:0]   name_char;
    logic         name_hit;
    logic         out_free;

    assign eff_limit = (val_limit_reg > VALUE_MAX_W) ? VALUE_MAX_W : val_limit_reg;
    assign count_inc = count_reg + 7'd1;
    assign pos_inc   = (pos_reg == 5'd31) ? pos_reg : pos_reg + 5'd1;
    assign c         = (cmd.op == OP_ORD_CR) ? CH_CR : byte_reg;
    assign name_vec  = {name_high_reg, name_low_reg};
    assign name_char = name_vec[{pos_reg[3:0], 3'b000} +: 8];
    assign name_hit  = !mism_reg && (name_len_reg <= NAME_MAX_W) && (pos_reg == name_len_reg);
    assign out_free  = !out_valid_reg || m_ready;

    assign status.act        = act_reg;
    assign status.done       = (phase_reg == PH_DONE);
    assign status.pend       = pend_reg;
    assign status.is_lf      = (byte_reg == CH_LF);
    assign status.is_cr      = (byte_reg == CH_CR);
    assign status.in_value   = (phase_reg == PH_SKIP) || (phase_reg == PH_VALUE);
    assign status.over       = (count_reg >= eff_limit);
    assign status.count_zero = (count_reg == 7'd0);
    assign status.rd_last    = ((7'(rd_idx_reg) + 7'd1) == count_reg);
    assign status.out_free   = out_free;

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        mism_next     = mism_reg;
        pend_next     = pend_reg;
        prev_emp_next = prev_emp_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        emit          = 1'b0;
        emit_kind     = K_ERROR;
        emit_byte     = 8'd0;
        wr_en         = 1'b0;
        wr_data       = c;
        case (cmd.op)
            OP_END: begin
                if (phase_reg != PH_DONE) begin
                    emit      = 1'b1;
                    emit_kind = (phase_reg == PH_NAME && pos_reg == 5'd0 && !pend_reg)
                                ? K_NOTFOUND : K_ERROR;
                end
                phase_next    = PH_NAME;
                pos_next      = 5'd0;
                mism_next     = 1'b0;
                pend_next     = 1'b0;
                prev_emp_next = 1'b0;
                count_next    = 7'd0;
            end
            OP_SET_CR: begin
                pend_next = 1'b1;
            end
            OP_ORD_CR, OP_ORD_BYTE: begin
                pend_next = 1'b0;
                case (phase_reg)
                    PH_NAME: begin
                        pos_next = pos_inc;
                        if (c == CH_COLON) begin
                            if (name_hit) begin
                                phase_next = PH_SKIP;
                                count_next = 7'd0;
                            end else begin
                                phase_next = PH_REST;
                            end
                        end else if (pos_reg >= name_len_reg || pos_reg >= NAME_MAX_W ||
                                     to_lower(c) != to_lower(name_char)) begin
                            mism_next = 1'b1;
                        end
                    end
                    PH_SKIP, PH_VALUE: begin
                        if (!(phase_reg == PH_SKIP && (c == CH_SPACE || c == CH_TAB))) begin
                            phase_next = PH_VALUE;
                            wr_en      = 1'b1;
                            count_next = count_inc;
                            if (count_inc >= eff_limit) begin
                                emit       = 1'b1;
                                emit_kind  = K_ERROR;
                                phase_next = PH_DONE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_LINE_END: begin
                pend_next   = 1'b0;
                rd_idx_next = '0;
                if (phase_reg == PH_SKIP || phase_reg == PH_VALUE) begin
                    if (count_reg >= eff_limit) begin
                        emit      = 1'b1;
                        emit_kind = K_ERROR;
                    end
                    phase_next = PH_DONE;
                end else if (phase_reg == PH_NAME && pos_reg == 5'd0 && prev_emp_reg) begin
                    emit       = 1'b1;
                    emit_kind  = K_NOTFOUND;
                    phase_next = PH_DONE;
                end else begin
                    prev_emp_next = (phase_reg == PH_NAME && pos_reg == 5'd0);
                    phase_next    = PH_NAME;
                    pos_next      = 5'd0;
                    mism_next     = 1'b0;
                end
            end
            OP_EMIT_BYTE: begin
                emit        = 1'b1;
                emit_kind   = K_VALUE;
                emit_byte   = rd_data_reg;
                rd_idx_next = rd_idx_reg + 1'b1;
            end
            OP_FOUND: begin
                emit      = 1'b1;
                emit_kind = K_FOUND;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_low_reg  <= '0;
            name_high_reg <= '0;
            name_len_reg  <= '0;
            val_limit_reg <= VAL_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_NAME_LOW:  name_low_reg  <= cfg_data;
                REG_NAME_HIGH: name_high_reg <= cfg_data;
                REG_NAME_LEN:  name_len_reg  <= cfg_data[4:0];
                REG_VAL_LIMIT: val_limit_reg <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= s_action;
            byte_reg <= s_text_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_NAME;
            pos_reg       <= '0;
            mism_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            prev_emp_reg  <= 1'b0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            mism_reg      <= mism_next;
            pend_reg      <= pend_next;
            prev_emp_reg  <= prev_emp_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= emit ? 1'b1 : (out_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_kind_reg <= emit_kind;
            out_byte_reg <= emit_byte;
            out_last_reg <= (emit_kind != K_VALUE);
        end
    end

    // value store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[IDX_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_RD) begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_kind       = out_kind_reg;
    assign m_value_byte = out_byte_reg;
    assign m_last       = out_last_reg;

endmodule

// ----- src/header_field_lookup.sv -----
// header field lookup: takes header text one word per accepted input, an
// action of 1 meaning end of string, and reports the value of the first line
// whose name (text before its first colon) matches the configured name,
// ignoring ascii letter case. results are a burst of value bytes closed by a
// found word, or a single not found or error word; the closing word carries
// m_last. the block takes one word at a time: a text byte is accepted and
// then takes one evaluation step, with an extra step when a held cr turns
// out to be an ordinary byte; an end of string word likewise. a cr lf ending
// a matched line starts a read-out of the value store, a read request and an
// emit step per byte, then the found word, paced by the registered read port.
// a result waits in the output register, and every evaluation step and every
// read-out word stalls while a result is still held there unaccepted, even
// when the step itself produces no result. the store needs no clearing pass
// after reset.
// configuration writes are taken on every cycle (cfg_ready is tied high) and
// are only meant to happen while the block is idle.
module header_field_lookup #(
    parameter int NAME_MAX  = 16,
    parameter int VALUE_MAX = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hfl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [7:0]                    s_text_byte,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_kind,
    output logic [7:0]                    m_value_byte,
    output logic                          m_last
);
    import hfl_pkg::*;

    hfl_cmd_t    cmd;
    hfl_status_t status;

    // registers take every write
    assign cfg_ready = 1'b1;

    // sequencer: handshake, per word step order, value read-out
    hfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // parse state, name compare, value store, output register
    hfl_datapath #(
        .NAME_MAX  (NAME_MAX),
        .VALUE_MAX (VALUE_MAX)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_action     (s_action),
        .s_text_byte  (s_text_byte),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_value_byte (m_value_byte),
        .m_last       (m_last)
    );

endmodule

// ----- src/hfl_checker.sv -----
module hfl_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_kind,
    input logic [7:0] m_value_byte,
    input logic       m_last
);
    import hfl_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_value_byte)
                                && $stable(m_last))
        else $error("result word changed while stalled");

    // value bytes never close a run
    a_value_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == K_VALUE |-> !m_last)
        else $error("value byte flagged last");

    // status words close the run and carry a zero byte
    a_status_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != K_VALUE |-> m_last && m_value_byte == 8'd0)
        else $error("status word malformed");

    // every accepted word needs an evaluation step before the next is accepted
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on back to back cycles");

endmodule

bind header_field_lookup hfl_checker u_hfl_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import hfl_pkg::*;

    localparam int NAME_CAP  = 16;
    localparam int VALUE_CAP = 64;
    // cycles with no word moving on any channel before the run is declared hung
    localparam int WATCHDOG  = 1000;
    // quiet cycles allowed after the last expected result for a word still in flight
    localparam int DRAIN     = 8;

    typedef struct packed {
        logic       action;
        logic [7:0] text;
    } text_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } lookup_result_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #10 aclk = ~aclk;

    // configuration write channel
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_NAME_LOW;
    logic [63:0]          cfg_data  = '0;

    // text word channel
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic       s_action    = 1'b0;
    logic [7:0] s_text_byte = 8'h00;

    // result word channel
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_kind;
    logic [7:0] m_value_byte;
    logic       m_last;

    header_field_lookup i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_text_byte (s_text_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_value_byte(m_value_byte),
        .m_last      (m_last)
    );

    // words waiting to be sent, and results the lookup still owes us
    text_word_t     pending_words[$];
    lookup_result_t results_due[$];

    // register copies as the block holds them (reset values)
    logic [63:0] cfg_name_low  = '0;
    logic [63:0] cfg_name_high = '0;
    logic [4:0]  cfg_name_len  = 5'd0;
    logic [6:0]  cfg_val_limit = VAL_LIMIT_RST;

    // scanner state of the predictor
    logic [2:0] sc_phase = PH_NAME;
    int         sc_pos   = 0;
    bit         sc_miss  = 1'b0;
    bit         sc_cr    = 1'b0;
    bit         sc_blank = 1'b0;
    logic [7:0] val_buf[VALUE_CAP];
    int         val_cnt  = 0;

    // stimulus side view of the header being searched for
    logic [7:0] gen_name[NAME_CAP];
    int         gen_len   = 0;
    int         gen_limit = VALUE_CAP;
    string      alphabet  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-";
    int         words_queued = 0;

    // handshake bookkeeping
    bit         calm = 1'b0;       // no idling on either side when set
    bit         s_taken = 1'b0;    // the word on the input was accepted at the last edge
    int         s_gap = 0;
    int         r_gap = 0;
    text_word_t next_word;
    lookup_result_t want;
    int         quiet_cycles = 0;

    // tallies
    int errors     = 0;
    int n_text     = 0;
    int n_end      = 0;
    int n_writes   = 0;
    int n_values   = 0;
    int n_found    = 0;
    int n_notfound = 0;
    int n_error    = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] fold_case(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // configured name character i
    function automatic logic [7:0] name_char(int i);
        if (i < 8)
            return cfg_name_low[8*(i & 7) +: 8];
        return cfg_name_high[8*((i - 8) & 7) +: 8];
    endfunction

    // usable value capacity; limits above the store size act as the store size
    function automatic int value_room();
        return (cfg_val_limit > VALUE_CAP) ? VALUE_CAP : int'(cfg_val_limit);
    endfunction

    task automatic queue_result(logic [1:0] kind, logic [7:0] data, logic last);
        lookup_result_t r;
        r.kind = kind;
        r.data = data;
        r.last = last;
        results_due.push_back(r);
    endtask

    task automatic rearm_scan();
        sc_phase = PH_NAME;
        sc_pos   = 0;
        sc_miss  = 1'b0;
        sc_cr    = 1'b0;
        sc_blank = 1'b0;
        val_cnt  = 0;
    endtask

    // one character that is not part of a line break
    task automatic scan_char(logic [7:0] c);
        case (sc_phase)
            PH_NAME: begin
                if (c == CH_COLON) begin
                    // first colon closes the name
                    if (!sc_miss && cfg_name_len <= NAME_CAP && sc_pos == cfg_name_len) begin
                        sc_phase = PH_SKIP;
                        val_cnt  = 0;
                    end else begin
                        sc_phase = PH_REST;
                    end
                end else if (sc_pos >= cfg_name_len || sc_pos >= NAME_CAP ||
                             fold_case(c) != fold_case(name_char(sc_pos))) begin
                    sc_miss = 1'b1;
                end
                if (sc_pos < 31)
                    sc_pos++;
            end
            PH_SKIP, PH_VALUE: begin
                // leading blanks after the colon are dropped
                if (!(sc_phase == PH_SKIP && (c == CH_SPACE || c == CH_TAB))) begin
                    sc_phase = PH_VALUE;
                    val_buf[val_cnt % VALUE_CAP] = c;
                    val_cnt++;
                    if (val_cnt >= value_room()) begin
                        queue_result(K_ERROR, 8'h00, 1'b1);
                        sc_phase = PH_DONE;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // cr lf seen
    task automatic close_line();
        int i;
        if (sc_phase == PH_SKIP || sc_phase == PH_VALUE) begin
            if (val_cnt >= value_room()) begin
                queue_result(K_ERROR, 8'h00, 1'b1);
            end else begin
                for (i = 0; i < val_cnt && i < VALUE_CAP; i++)
                    queue_result(K_VALUE, val_buf[i], 1'b0);
                queue_result(K_FOUND, 8'h00, 1'b1);
            end
            sc_phase = PH_DONE;
        end else if (sc_phase == PH_NAME && sc_pos == 0 && sc_blank) begin
            // second empty line in a row ends the header
            queue_result(K_NOTFOUND, 8'h00, 1'b1);
            sc_phase = PH_DONE;
        end else begin
            sc_blank = (sc_phase == PH_NAME && sc_pos == 0);
            sc_phase = PH_NAME;
            sc_pos   = 0;
            sc_miss  = 1'b0;
        end
    endtask

    // one accepted input word
    task automatic scan_word(logic action, logic [7:0] b);
        bit line_done;
        line_done = 1'b0;
        if (action) begin
            // end of string: report unless already reported, then rearm
            if (sc_phase != PH_DONE) begin
                if (sc_phase == PH_NAME && sc_pos == 0 && !sc_cr)
                    queue_result(K_NOTFOUND, 8'h00, 1'b1);
                else
                    queue_result(K_ERROR, 8'h00, 1'b1);
            end
            rearm_scan();
        end else if (sc_phase != PH_DONE) begin
            if (sc_cr) begin
                sc_cr = 1'b0;
                if (b == CH_LF) begin
                    close_line();
                    line_done = 1'b1;
                end else begin
                    // a held cr without lf is an ordinary character
                    scan_char(CH_CR);
                end
            end
            if (!line_done && sc_phase != PH_DONE) begin
                if (b == CH_CR)
                    sc_cr = 1'b1;
                else
                    scan_char(b);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // input driver: next word at the falling edge, held until accepted
    // ------------------------------------------------------------------

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_taken) begin
            // word still waiting for the block
        end else if (s_gap != 0) begin
            s_valid <= 1'b0;
            s_gap   <= s_gap - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            // start an idle burst of random length
            s_valid <= 1'b0;
            s_gap   <= $urandom_range(0, 3);
        end else if (pending_words.size() != 0) begin
            next_word    = pending_words.pop_front();
            s_valid     <= 1'b1;
            s_action    <= next_word.action;
            s_text_byte <= next_word.text;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result side back-pressure in random bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (r_gap != 0) begin
            m_ready <= 1'b0;
            r_gap   <= r_gap - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            r_gap   <= $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: register copies, prediction, result check, watchdog
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_NAME_LOW:  cfg_name_low  = cfg_data;
                    REG_NAME_HIGH: cfg_name_high = cfg_data;
                    REG_NAME_LEN:  cfg_name_len  = cfg_data[4:0];
                    REG_VAL_LIMIT: cfg_val_limit = cfg_data[6:0];
                    default: ;
                endcase
                n_writes++;
            end

            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result word with none expected: kind %0d byte %02h last %0d",
                             $time, m_kind, m_value_byte, m_last);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (m_kind !== want.kind) begin
                        $display("%0t: kind mismatch, expected %0d, actual %0d",
                                 $time, want.kind, m_kind);
                        errors++;
                    end
                    if (m_value_byte !== want.data) begin
                        $display("%0t: value byte mismatch, expected %02h, actual %02h",
                                 $time, want.data, m_value_byte);
                        errors++;
                    end
                    if (m_last !== want.last) begin
                        $display("%0t: last mismatch, expected %0d, actual %0d",
                                 $time, want.last, m_last);
                        errors++;
                    end
                    case (want.kind)
                        K_VALUE:    n_values++;
                        K_FOUND:    n_found++;
                        K_NOTFOUND: n_notfound++;
                        default:    n_error++;
                    endcase
                end
            end

            if (s_valid && s_ready) begin
                scan_word(s_action, s_text_byte);
                if (s_action)
                    n_end++;
                else
                    n_text++;
            end

            // watchdog on channel activity
            if ((cfg_valid && cfg_ready) || (m_valid && m_ready) || (s_valid && s_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG);
                $display("header_field_lookup verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_word(logic action, logic [7:0] b);
        text_word_t w;
        w.action = action;
        w.text   = b;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic add_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_word(1'b0, s[i]);
    endtask

    task automatic add_crlf();
        add_word(1'b0, CH_CR);
        add_word(1'b0, CH_LF);
    endtask

    // end of string; the byte field is don't care here
    task automatic add_end();
        add_word(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // wait for the block to go idle: all words in, all results out, last word settled
    task automatic settle();
        while (pending_words.size() != 0 || s_valid || results_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic use_name(string nm);
        int i;
        gen_len = nm.len();
        for (i = 0; i < gen_len; i++)
            gen_name[i] = nm[i];
    endtask

    // random name; letters, digits and hyphens, or any byte that cannot end the name early
    task automatic pick_name(int len, bit any_byte);
        int i;
        logic [7:0] c;
        gen_len = len;
        for (i = 0; i < len; i++) begin
            if (any_byte) begin
                do c = 8'($urandom_range(1, 255));
                while (c == CH_COLON || c == CH_CR || c == CH_LF);
            end else begin
                c = alphabet[$urandom_range(0, alphabet.len() - 1)];
            end
            gen_name[i] = c;
        end
    endtask

    // name registers: chars past the length are filler and must not matter
    task automatic program_name(logic [63:0] fill_low, logic [63:0] fill_high);
        int i;
        logic [63:0] lo;
        logic [63:0] hi;
        lo = fill_low;
        hi = fill_high;
        for (i = 0; i < gen_len; i++) begin
            if (i < 8)
                lo[8*i +: 8] = gen_name[i];
            else
                hi[8*(i-8) +: 8] = gen_name[i];
        end
        write_reg(REG_NAME_LOW, lo);
        write_reg(REG_NAME_HIGH, hi);
        write_reg(REG_NAME_LEN, 64'(gen_len));
    endtask

    // one header: one or two lines, then some way of ending the string
    task automatic header_block();
        int nlines;
        int n;
        int k;
        int len;
        int kind;
        int cut;
        logic [7:0] c;

        // occasional raw noise, end words mixed in
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 6);
            for (k = 0; k < len; k++)
                add_word($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
        end

        nlines = $urandom_range(1, 2);
        for (n = 0; n < nlines; n++) begin
            kind = $urandom_range(0, 9);
            if (kind == 7) begin
                add_crlf();            // empty line
                continue;
            end
            if (kind <= 3) begin
                // the wanted name, letter case scrambled
                for (k = 0; k < gen_len; k++) begin
                    c = gen_name[k];
                    if (fold_case(c) >= "a" && fold_case(c) <= "z" && $urandom_range(0, 1))
                        c = c ^ 8'h20;
                    add_word(1'b0, c);
                end
            end else if (kind <= 5) begin
                // near miss: one char short, one too many, or one char off
                cut = $urandom_range(0, 2);
                len = (cut == 0) ? gen_len - 1 : gen_len;
                kind = $urandom_range(0, gen_len - 1);
                for (k = 0; k < len; k++)
                    add_word(1'b0, (cut == 2 && k == kind) ? gen_name[k] + 8'd1 : gen_name[k]);
                if (cut == 1)
                    add_word(1'b0, alphabet[$urandom_range(0, alphabet.len() - 1)]);
            end else begin
                len = $urandom_range(0, 5);
                for (k = 0; k < len; k++)
                    add_word(1'b0, alphabet[$urandom_range(0, alphabet.len() - 1)]);
            end
            if ($urandom_range(0, 7) != 0)
                add_word(1'b0, CH_COLON);
            len = $urandom_range(0, 2);
            for (k = 0; k < len; k++)
                add_word(1'b0, $urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            // mostly short values, now and then right around the capacity
            if ($urandom_range(0, 11) == 0)
                len = gen_limit - 1 + $urandom_range(0, 2);
            else
                len = $urandom_range(0, 5);
            for (k = 0; k < len; k++)
                add_word(1'b0, 8'($urandom_range(1, 255)));
            add_crlf();
        end

        case ($urandom_range(0, 5))
            3: begin
                add_crlf();            // blank line pair
                add_crlf();
            end
            4: begin
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                    add_word(1'b0, 8'($urandom_range(1, 255)));
            end
            5: begin
                // string cut off in the middle of a name
                for (k = 0; k < gen_len && k < 3; k++)
                    add_word(1'b0, gen_name[k]);
            end
            default: ;
        endcase
        add_end();
    endtask

    task automatic random_headers(int budget);
        int start;
        start = words_queued;
        while (words_queued - start < budget)
            header_block();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: empty name, full capacity
        add_end();                                 // end at line start: not found
        add_word(1'b0, CH_COLON);                  // empty name matches at once
        add_word(1'b0, CH_TAB);
        add_word(1'b0, CH_SPACE);
        add_text("x");
        add_crlf();
        add_end();                                 // after a report it only rearms
        add_crlf();                                // two empty lines: not found
        add_crlf();
        add_end();
        settle();

        // short name, mixed case
        use_name("aB");
        program_name('0, '0);
        add_text("AB:");                           // empty value
        add_crlf();
        add_end();
        add_text("x");                             // end right after a lone cr
        add_word(1'b0, CH_CR);
        add_end();
        add_text("x");                             // end in mid-line
        add_end();
        add_text("a");                             // cr inside a name spoils it
        add_word(1'b0, CH_CR);
        add_text("b:v");
        add_crlf();
        add_text("ab:");                           // zero byte and lone cr in a value
        add_word(1'b0, 8'h00);
        add_word(1'b0, CH_CR);
        add_text("z");
        add_crlf();
        add_end();
        settle();

        // value hits the limit, rest of the line ignored
        write_reg(REG_VAL_LIMIT, 64'd3);
        add_text("ab:xyzw");
        add_end();
        settle();

        // zero limit: even an empty value is too long
        write_reg(REG_VAL_LIMIT, 64'd0);
        add_text("ab:");
        add_crlf();
        add_end();
        settle();

        // full length name of all ones
        write_reg(REG_NAME_LOW, '1);
        write_reg(REG_NAME_HIGH, '1);
        write_reg(REG_NAME_LEN, 64'd16);
        write_reg(REG_VAL_LIMIT, 64'd64);
        for (int i = 0; i < NAME_CAP; i++)
            add_word(1'b0, 8'hFF);
        add_text(":v");
        add_crlf();
        add_end();
        settle();

        // random headers, ordinary name, full capacity
        pick_name($urandom_range(1, 4), 1'b0);
        program_name({$urandom, $urandom}, {$urandom, $urandom});
        gen_limit = 64;
        write_reg(REG_VAL_LIMIT, 64'd64);
        random_headers(10);
        settle();

        // odd bytes in the name, tiny capacity
        pick_name($urandom_range(1, 3), 1'b1);
        program_name({$urandom, $urandom}, {$urandom, $urandom});
        gen_limit = $urandom_range(1, 6);
        write_reg(REG_VAL_LIMIT, 64'(gen_limit));
        random_headers(8);
        settle();

        // name length past the maximum never matches; limit past the store size
        write_reg(REG_NAME_LEN, 64'd31);
        write_reg(REG_VAL_LIMIT, 64'd127);
        gen_limit = 64;
        random_headers(6);
        settle();

        // last stretch at full rate on both sides
        calm = 1'b1;
        pick_name(2, 1'b0);
        program_name({$urandom, $urandom}, {$urandom, $urandom});
        write_reg(REG_VAL_LIMIT, 64'($urandom_range(65, 127)));
        gen_limit = 64;
        random_headers(10);

        while (pending_words.size() != 0 || s_valid || results_due.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("sent %0d text words and %0d end words across %0d register writes",
                 n_text, n_end, n_writes);
        $display("checked %0d value bytes, %0d found, %0d not found, %0d errors; %0d mismatches",
                 n_values, n_found, n_notfound, n_error, errors);
        if (errors == 0)
            $display("header_field_lookup verification clean");
        else
            $display("header_field_lookup verification failed");
        $finish;
    end

endmodule
